// ===== rtl/core/spsa_pkg.sv =====
// ----------------------------------------------------------------------------
// spsa_pkg
// Shared widths, request codes, controller states and the command and status
// bundles between the controller and the datapath of the scatter-add unit.
// ----------------------------------------------------------------------------
package spsa_pkg;

	localparam int DEF_TABLE_DEPTH = 64;

	localparam int FUNC_W = 2;
	localparam int ID_W   = 32;
	localparam int VAL_W  = 32;
	localparam int COL_W  = 6;

	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PAIR   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACC_WR,
		ST_ROW_END,
		ST_DRAIN_RD,
		ST_DRAIN_WR
	} state_t;

	typedef struct packed {
		logic append;
		logic clear_table;
		logic load_pair;
		logic scan_start;
		logic scan_run;
		logic acc_read_hit;
		logic acc_write;
		logic set_error;
		logic drain_start;
		logic drain_read;
		logic drain_emit;
		logic row_clear;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_append;
		logic in_clear;
		logic in_pair;
		logic in_skip;
		logic in_last;
		logic pair_last;
		logic scan_hit;
		logic scan_miss;
		logic tbl_empty;
		logic drain_last;
		logic out_free;
	} ctrl_stat_t;

endpackage

// ===== rtl/core/spsa_ram.sv =====
// ----------------------------------------------------------------------------
// spsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/spsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// spsa_ctrl
// Controller: sequences table scan, accumulator update and row drain.
// ----------------------------------------------------------------------------
module spsa_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  spsa_pkg::ctrl_stat_t   stat,
	output spsa_pkg::ctrl_cmd_t    cmd
);

	import spsa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && stat.in_pair) begin
					if (!stat.in_skip) begin
						state_d = ST_SCAN;
					end else if (stat.in_last) begin
						state_d = ST_ROW_END;
					end
				end
			end
			ST_SCAN: begin
				if (stat.scan_hit) begin
					state_d = ST_ACC_WR;
				end else if (stat.scan_miss) begin
					state_d = stat.pair_last ? ST_ROW_END : ST_IDLE;
				end
			end
			ST_ACC_WR: begin
				state_d = stat.pair_last ? ST_ROW_END : ST_IDLE;
			end
			ST_ROW_END: begin
				state_d = stat.tbl_empty ? ST_IDLE : ST_DRAIN_RD;
			end
			ST_DRAIN_RD: begin
				state_d = ST_DRAIN_WR;
			end
			ST_DRAIN_WR: begin
				if (stat.out_free) begin
					state_d = stat.drain_last ? ST_IDLE : ST_DRAIN_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.append      = in_valid && stat.in_append;
				cmd.clear_table = in_valid && stat.in_clear;
				cmd.load_pair   = in_valid && stat.in_pair;
				cmd.scan_start  = in_valid && stat.in_pair && !stat.in_skip;
			end
			ST_SCAN: begin
				cmd.scan_run     = 1'b1;
				cmd.acc_read_hit = stat.scan_hit;
				cmd.set_error    = stat.scan_miss;
			end
			ST_ACC_WR: begin
				cmd.acc_write = 1'b1;
			end
			ST_ROW_END: begin
				// empty table still ends the row
				cmd.row_clear   = stat.tbl_empty;
				cmd.drain_start = !stat.tbl_empty;
			end
			ST_DRAIN_RD: begin
				cmd.drain_read = 1'b1;
			end
			ST_DRAIN_WR: begin
				cmd.drain_emit = stat.out_free;
				cmd.row_clear  = stat.out_free && stat.drain_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/core/spsa_dp.sv =====
// ----------------------------------------------------------------------------
// spsa_dp
// Datapath: id table, accumulator memory with valid bits, row flags, scan
// pipeline and the output register.
// ----------------------------------------------------------------------------
module spsa_dp #(
	parameter int TABLE_DEPTH = spsa_pkg::DEF_TABLE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spsa_pkg::ctrl_cmd_t               cmd,
	output spsa_pkg::ctrl_stat_t              stat,
	input  logic [spsa_pkg::FUNC_W-1:0]       func,
	input  logic signed [spsa_pkg::ID_W-1:0]  sparse_id,
	input  logic signed [spsa_pkg::VAL_W-1:0] pair_value,
	input  logic                              row_last,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [spsa_pkg::COL_W-1:0]        dense_column,
	output logic signed [spsa_pkg::VAL_W-1:0] column_sum,
	output logic                              unknown_id,
	output logic                              last_of_row
);

	import spsa_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	function automatic logic signed [VAL_W-1:0] sat_add(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		logic signed [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1]) begin
			return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end
		return s[VAL_W-1:0];
	endfunction

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          k_q;
	logic [ID_W-1:0]           id_q;
	logic signed [VAL_W-1:0]   val_q;
	logic                      last_q;
	logic                      stopped_q;
	logic                      error_q;
	logic                      cmp_vld_s1;
	logic [IDX_W-1:0]          cmp_idx_s1;
	logic [IDX_W-1:0]          acc_addr_q;
	logic [TABLE_DEPTH-1:0]    acc_vld_q;
	logic                      out_valid_q;

	logic                      scan_issue;
	logic [ID_W-1:0]           tbl_rdata;
	logic                      tbl_wr_en;
	logic                      acc_rd_en;
	logic [IDX_W-1:0]          acc_rd_addr;
	logic [VAL_W-1:0]          acc_rdata;
	logic signed [VAL_W-1:0]   acc_cur;
	logic signed [VAL_W-1:0]   acc_new;
	logic                      drain_last;
	logic                      out_free;

	assign scan_issue  = (k_q < count_q);
	assign tbl_wr_en   = cmd.append && (count_q < DEPTH_C);
	assign acc_rd_en   = cmd.acc_read_hit || cmd.drain_read;
	assign acc_rd_addr = cmd.acc_read_hit ? cmp_idx_s1 : k_q[IDX_W-1:0];
	// a column not written this row reads as zero
	assign acc_cur     = acc_vld_q[acc_addr_q] ? acc_rdata : '0;
	assign acc_new     = sat_add(acc_cur, val_q);
	assign drain_last  = ((k_q + CNT_W'(1)) == count_q);
	assign out_free    = !out_valid_q || !out_stall;

	spsa_ram #(
		.WIDTH (ID_W),
		.DEPTH (TABLE_DEPTH)
	) u_id_ram (
		.clk     (clk),
		.wr_en   (tbl_wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (sparse_id),
		.rd_en   (cmd.scan_run && scan_issue),
		.rd_addr (k_q[IDX_W-1:0]),
		.rd_data (tbl_rdata)
	);

	spsa_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TABLE_DEPTH)
	) u_acc_ram (
		.clk     (clk),
		.wr_en   (cmd.acc_write),
		.wr_addr (acc_addr_q),
		.wr_data (acc_new),
		.rd_en   (acc_rd_en),
		.rd_addr (acc_rd_addr),
		.rd_data (acc_rdata)
	);

	always_comb begin
		stat            = '0;
		stat.in_append  = (func == FUNC_APPEND);
		stat.in_clear   = (func == FUNC_CLEAR);
		stat.in_pair    = (func == FUNC_PAIR);
		stat.in_skip    = sparse_id[ID_W-1] || stopped_q;
		stat.in_last    = row_last;
		stat.pair_last  = last_q;
		// first match in table order wins
		stat.scan_hit   = cmp_vld_s1 && (tbl_rdata == id_q);
		stat.scan_miss  = !cmp_vld_s1 && !scan_issue;
		stat.tbl_empty  = (count_q == '0);
		stat.drain_last = drain_last;
		stat.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			k_q         <= '0;
			stopped_q   <= 1'b0;
			error_q     <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			acc_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_table) begin
				count_q <= '0;
			end else if (tbl_wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end

			if (cmd.scan_start || cmd.drain_start) begin
				k_q <= '0;
			end else if ((cmd.scan_run && scan_issue) || cmd.drain_emit) begin
				k_q <= k_q + CNT_W'(1);
			end

			if (cmd.scan_start) begin
				cmp_vld_s1 <= 1'b0;
			end else if (cmd.scan_run) begin
				cmp_vld_s1 <= scan_issue;
			end

			if (cmd.clear_table || cmd.row_clear) begin
				stopped_q <= 1'b0;
				error_q   <= 1'b0;
				acc_vld_q <= '0;
			end else begin
				if (cmd.load_pair && sparse_id[ID_W-1]) begin
					stopped_q <= 1'b1;
				end
				if (cmd.set_error) begin
					error_q <= 1'b1;
				end
				if (cmd.acc_write) begin
					acc_vld_q[acc_addr_q] <= 1'b1;
				end
			end

			if (cmd.drain_emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pair) begin
			id_q   <= sparse_id;
			val_q  <= pair_value;
			last_q <= row_last;
		end
		if (cmd.scan_run) begin
			cmp_idx_s1 <= k_q[IDX_W-1:0];
		end
		if (acc_rd_en) begin
			acc_addr_q <= acc_rd_addr;
		end
		if (cmd.drain_emit) begin
			dense_column <= COL_W'(k_q[IDX_W-1:0]);
			column_sum   <= acc_cur;
			unknown_id   <= error_q;
			last_of_row  <= drain_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/sparse_pair_scatter_accumulate_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_pair_scatter_accumulate_unit
// Sparse-to-dense row projection with saturating Q16.16 column sums.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (in_valid/in_stall) and carry func,
// sparse_id, pair_value and row_last. An append request stores sparse_id in
// the next table slot, whose position is its dense column; a clear request
// empties the table and abandons the row in progress. A pair request scans
// the id table one entry per cycle through the table RAM read port, up to
// the first entry holding its id or to the end when the id is missing,
// followed by an accumulator read-modify-write on a hit. A pair with a
// negative id, or any pair after one in the same row, is skipped without a
// scan. On the row's last pair, every column 0 .. table_count-1 is sent on
// the output channel (out_valid/out_stall), each read through the
// accumulator RAM read port; a column waits in the output register while
// out_stall is high, and the last column may wait there while the next
// request is already taken.
// Reset empties the table, zeroes every accumulator through per-column valid
// bits and clears the row flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sparse_pair_scatter_accumulate_unit #(
	parameter int TABLE_DEPTH = spsa_pkg::DEF_TABLE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [spsa_pkg::FUNC_W-1:0]       func,
	input  logic signed [spsa_pkg::ID_W-1:0]  sparse_id,
	input  logic signed [spsa_pkg::VAL_W-1:0] pair_value,
	input  logic                              row_last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [spsa_pkg::COL_W-1:0]        dense_column,
	output logic signed [spsa_pkg::VAL_W-1:0] column_sum,
	output logic                              unknown_id,
	output logic                              last_of_row
);

	import spsa_pkg::*;

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	spsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	spsa_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (func),
		.sparse_id    (sparse_id),
		.pair_value   (pair_value),
		.row_last     (row_last),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.dense_column (dense_column),
		.column_sum   (column_sum),
		.unknown_id   (unknown_id),
		.last_of_row  (last_of_row)
	);

endmodule

// ===== rtl/core/spsa_checker.sv =====
// ----------------------------------------------------------------------------
// spsa_checker
// Port-level checks of the scatter-add unit, bound to the top level.
// ----------------------------------------------------------------------------
module spsa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [spsa_pkg::COL_W-1:0]        dense_column,
	input logic signed [spsa_pkg::VAL_W-1:0] column_sum,
	input logic                              unknown_id,
	input logic                              last_of_row
);

	import spsa_pkg::*;

	logic             out_acc;
	logic             in_acc;
	logic [COL_W-1:0] exp_col_q;
	logic             in_row_q;
	logic             row_unknown_q;

	assign out_acc = out_valid && !out_stall;
	assign in_acc  = in_valid && !in_stall;

	// track the column order and row flag seen on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_col_q     <= '0;
			in_row_q      <= 1'b0;
			row_unknown_q <= 1'b0;
		end else if (out_acc) begin
			exp_col_q     <= last_of_row ? '0 : dense_column + COL_W'(1);
			in_row_q      <= !last_of_row;
			row_unknown_q <= unknown_id;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(dense_column) &&
			$stable(column_sum) && $stable(unknown_id) && $stable(last_of_row))
		else $error("stalled result changed or dropped");

	a_no_result_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(out_valid))
		else $error("result appeared right after a request");

	a_column_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> dense_column == exp_col_q)
		else $error("dense columns out of order");

	a_row_flag_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && in_row_q |-> unknown_id == row_unknown_q)
		else $error("unknown id flag changed within a row");

	a_drain_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q |-> in_stall || out_valid)
		else $error("request taken in the middle of a row drain");

endmodule

bind sparse_pair_scatter_accumulate_unit spsa_checker u_spsa_checker (.*);
